// File: sv/b64_pkg.sv
package b64_pkg;

  // most results that one accepted request can cause: four characters and a terminator
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntWidth   = $clog2(MaxResults + 1);

  // configuration register indexes
  localparam logic CFG_MODE       = 1'b0;
  localparam logic CFG_APPEND_NUL = 1'b1;

  // mode register codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3d;

  // results of one request, handed from the front end to the emitter
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CntWidth-1:0]        cnt;
    logic                       last;
    logic                       err;
  } b64_rec_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      enc_char = w + 8'h41;
    end else if (v < 6'd52) begin
      enc_char = w + 8'h47;
    end else if (v < 6'd62) begin
      enc_char = w - 8'h04;
    end else if (v == 6'd62) begin
      enc_char = 8'h2b;
    end else begin
      enc_char = 8'h2f;
    end
  endfunction

  // alphabet character to 6-bit value, anything else gives zero
  function automatic logic [5:0] dec_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      t = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      t = c - 8'h47;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'h04;
    end else if (c == 8'h2b) begin
      t = 8'd62;
    end else if (c == 8'h2f) begin
      t = 8'd63;
    end
    dec_value = t[5:0];
  endfunction

endpackage

// File: sv/b64_front.sv
module b64_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic             append_nul_i,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_end_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             push_o,
  output b64_pkg::b64_rec_t rec_o
);
  import b64_pkg::*;

  logic [23:0] group_bits_q, group_bits_d;
  logic [1:0]  group_count_q, group_count_d;
  logic        pad_seen_q, pad_seen_d;

  logic [2:0]          total;
  logic [23:0]         bits;
  logic [CntWidth-1:0] n;
  logic                err;
  logic                take;
  logic [7:0]          c0, c1, c2, c3;
  logic [5:0]          v0, v1, v2, v3;
  logic                pad_next;
  b64_rec_t            rec;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;

  assign c0 = group_bits_q[23:16];
  assign c1 = group_bits_q[15:8];
  assign c2 = group_bits_q[7:0];
  assign c3 = in_byte_i;
  assign v0 = dec_value(c0);
  assign v1 = dec_value(c1);
  assign v2 = dec_value(c2);
  assign v3 = dec_value(c3);

  always_comb begin
    total    = {1'b0, group_count_q} + 3'd1;
    bits     = {group_bits_q[15:0], in_byte_i};
    n        = '0;
    err      = 1'b0;
    pad_next = pad_seen_q;
    rec      = '0;
    if (mode_i == MODE_ENCODE) begin
      if (total >= 3'd3) begin
        rec.bytes[0] = enc_char(bits[23:18]);
        rec.bytes[1] = enc_char(bits[17:12]);
        rec.bytes[2] = enc_char(bits[11:6]);
        rec.bytes[3] = enc_char(bits[5:0]);
        n     = CntWidth'(4);
        total = 3'd0;
        bits  = '0;
      end else if (in_end_i && total == 3'd1) begin
        rec.bytes[0] = enc_char(bits[7:2]);
        rec.bytes[1] = enc_char({bits[1:0], 4'b0000});
        rec.bytes[2] = PAD_CHAR;
        rec.bytes[3] = PAD_CHAR;
        n = CntWidth'(4);
      end else if (in_end_i && total == 3'd2) begin
        rec.bytes[0] = enc_char(bits[15:10]);
        rec.bytes[1] = enc_char({bits[9:8], bits[7:4]});
        rec.bytes[2] = enc_char({bits[3:0], 2'b00});
        rec.bytes[3] = PAD_CHAR;
        n = CntWidth'(4);
      end
    end else begin
      if (total == 3'd4) begin
        if (!pad_seen_q) begin
          rec.bytes[0] = {v0, v1[5:4]};
          n = CntWidth'(1);
          if (c1 == PAD_CHAR || c2 == PAD_CHAR) begin
            pad_next = 1'b1;
          end else begin
            rec.bytes[1] = {v1[3:0], v2[5:2]};
            n = CntWidth'(2);
            if (c2 == PAD_CHAR || c3 == PAD_CHAR) begin
              pad_next = 1'b1;
            end else begin
              rec.bytes[2] = {v2[1:0], v3};
              n = CntWidth'(3);
            end
          end
        end
        total = 3'd0;
        bits  = '0;
      end
      if (in_end_i && total != 3'd0) begin
        err = 1'b1;
      end
    end
    // terminator slot is already zero, only the count grows
    if (in_end_i && (append_nul_i || n == '0)) begin
      n = n + CntWidth'(1);
    end
    rec.cnt  = n;
    rec.last = in_end_i;
    rec.err  = err;
  end

  always_comb begin
    group_bits_d  = group_bits_q;
    group_count_d = group_count_q;
    pad_seen_d    = pad_seen_q;
    if (take) begin
      if (in_end_i) begin
        group_bits_d  = '0;
        group_count_d = '0;
        pad_seen_d    = 1'b0;
      end else begin
        group_bits_d  = bits;
        group_count_d = total[1:0];
        pad_seen_d    = pad_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_bits_q  <= '0;
      group_count_q <= '0;
      pad_seen_q    <= 1'b0;
    end else begin
      group_bits_q  <= group_bits_d;
      group_count_q <= group_count_d;
      pad_seen_q    <= pad_seen_d;
    end
  end

  assign push_o = take && (rec.cnt != '0);
  assign rec_o  = rec;

endmodule

// File: sv/b64_fifo.sv
module b64_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64_pkg::b64_rec_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output b64_pkg::b64_rec_t rdata_o
);
  import b64_pkg::*;

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NumWidth = $clog2(Depth + 1);

  b64_rec_t             mem_q [Depth];
  logic [PtrWidth-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]  rd_ptr_q, rd_ptr_d;
  logic [NumWidth-1:0]  num_q, num_d;
  logic                 do_push, do_pop;

  assign full_o  = (num_q == NumWidth'(Depth));
  assign valid_o = (num_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    num_d    = num_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      num_d = num_q + NumWidth'(1);
    end else if (do_pop && !do_push) begin
      num_d = num_q - NumWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      num_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      num_q    <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/b64_back.sv
module b64_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rec_valid_i,
  input  b64_pkg::b64_rec_t rec_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic             out_err_o
);
  import b64_pkg::*;

  b64_rec_t            work_q, work_d;
  logic                work_valid_q, work_valid_d;
  logic [CntWidth-1:0] idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;
  logic                out_err_q, out_err_d;

  logic       out_free, advance, work_done, load;
  logic [7:0] cur_byte;

  assign out_free  = !out_valid_q || out_ready_i;
  assign advance   = work_valid_q && out_free;
  assign work_done = advance && (idx_q == work_q.cnt - CntWidth'(1));
  assign load      = rec_valid_i && (!work_valid_q || work_done);
  assign pop_o     = load;

  always_comb begin
    case (idx_q)
      CntWidth'(0): cur_byte = work_q.bytes[0];
      CntWidth'(1): cur_byte = work_q.bytes[1];
      CntWidth'(2): cur_byte = work_q.bytes[2];
      CntWidth'(3): cur_byte = work_q.bytes[3];
      CntWidth'(4): cur_byte = work_q.bytes[4];
      default:      cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    work_d       = work_q;
    work_valid_d = work_valid_q;
    idx_d        = idx_q;
    if (load) begin
      work_d       = rec_i;
      work_valid_d = 1'b1;
      idx_d        = '0;
    end else if (work_done) begin
      work_valid_d = 1'b0;
    end else if (advance) begin
      idx_d = idx_q + CntWidth'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = work_done && work_q.last;
      out_err_d   = work_done && work_q.err;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

endmodule

// File: sv/base64_codec.sv
// streaming base64 codec, standard alphabet
// slave side takes one byte per request: message bytes when encoding, characters when
// decoding; tlast marks the final request of a message
// master side gives one byte per request: characters or decoded bytes, then an optional
// zero terminator; tlast marks the final result of a message, tuser flags a decode
// message whose length was not a multiple of four
// mode and append_nul are set through the write port; the user must do so only while
// the codec is idle, the codec itself does not enforce it
// a request is classified in the cycle it is accepted; its results (none to five) go into
// a small record queue and the emitter drains them one byte per cycle while the output
// register is free; records pass the queue and the emitter's work register, their bytes
// then the output register on the way to the master side
// encoding gives four results per three requests, decoding takes one request a cycle
// a stalled receiver holds the output register; the emitter and the queue fill up and
// then tready drops, with the front end waiting on the queue
// reset empties the queue and the emitter, clears the open group, mode goes to encode
// and append_nul to one
module base64_codec #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_data_i,
  // slave side
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // data_byte
  input  logic       s_axis_tlast_i,   // msg_end
  // master side
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // out_byte
  output logic       m_axis_tlast_o,   // out_last
  output logic       m_axis_tuser_o    // error
);
  import b64_pkg::*;

  logic     mode_q, mode_d;
  logic     append_nul_q, append_nul_d;
  logic     q_full, push, pop, q_valid;
  b64_rec_t push_rec, head_rec;

  // configuration registers
  always_comb begin
    mode_d       = mode_q;
    append_nul_d = append_nul_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:       mode_d       = cfg_data_i;
        CFG_APPEND_NUL: append_nul_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_ENCODE;
      append_nul_q <= 1'b1;
    end else begin
      mode_q       <= mode_d;
      append_nul_q <= append_nul_d;
    end
  end

  // front end: group tracking and result building
  b64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .append_nul_i(append_nul_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_byte_i   (s_axis_tdata_i),
    .in_end_i    (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // record queue between classification and emission
  b64_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_rec),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rdata_o(head_rec)
  );

  // emitter: one byte per cycle into the output register while that register is free
  b64_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(q_valid),
    .rec_i      (head_rec),
    .pop_o      (pop),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_byte_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o),
    .out_err_o  (m_axis_tuser_o)
  );

endmodule

// File: dv/base64_codec_tb.sv
module base64_codec_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import b64_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  // enough for a request that causes no result to clear the front end
  localparam int unsigned SETTLE_CYCLES  = 12;
  // long receiver hold-off, long enough to back the codec up into its input
  localparam int unsigned HOLD_CYCLES    = 300;
  // cycles without any request or result moving before the run is given up
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TOTAL_ITEMS    = 480;
  localparam int unsigned CALM_FROM      = 420;

  // standard alphabet, index 0 is 'A'
  localparam logic [0:63][7:0] B64_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // one output byte as seen on the master side
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } codec_out_t;

  // one row of the directed table; want_n of zero leaves the row to the predictor,
  // otherwise the first want_n bytes are the typed-in results, the last one carrying
  // tlast and want_err
  typedef struct packed {
    logic            mode;
    logic            nul;
    logic [7:0]      data;
    logic            fin;
    logic [2:0]      want_n;
    logic [0:4][7:0] want;
    logic            want_err;
  } dir_row_t;

  localparam logic [0:4][7:0] NO_WANT = '0;

  localparam dir_row_t DIR_TABLE [25] = '{
    // right after reset: encode with terminator, single byte gets double padding
    '{MODE_ENCODE, 1'b1, 8'h4d, 1'b1, 3'd5, {"TQ==", 8'h00},             1'b0},
    // all-zero full group
    '{MODE_ENCODE, 1'b1, 8'h00, 1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_ENCODE, 1'b1, 8'h00, 1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_ENCODE, 1'b1, 8'h00, 1'b1, 3'd5, {"AAAA", 8'h00},             1'b0},
    // all-ones pair, single padding
    '{MODE_ENCODE, 1'b1, 8'hff, 1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_ENCODE, 1'b1, 8'hff, 1'b1, 3'd5, {"//8=", 8'h00},             1'b0},
    // encode without terminator, tlast on the last pad character
    '{MODE_ENCODE, 1'b0, 8'h00, 1'b1, 3'd4, {"AA==", 8'h00},             1'b0},
    // plain decode of a full group
    '{MODE_DECODE, 1'b1, "T",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b1, "W",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b1, "F",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b1, "u",   1'b1, 3'd4, {8'h4d, 8'h61, 8'h6e, 16'h0}, 1'b0},
    // decode stops at a pad in the third place
    '{MODE_DECODE, 1'b1, "T",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b1, "Q",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b1, "=",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b1, "=",   1'b1, 3'd2, {8'h4d, 32'h0},              1'b0},
    // short decode message, no terminator: only the forced end marker with the error
    '{MODE_DECODE, 1'b0, "A",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b0, "B",   1'b1, 3'd1, {8'h00, 32'h0},              1'b1},
    // characters outside the alphabet, pad stop, then characters after the stop
    '{MODE_DECODE, 1'b0, "A",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b0, 8'hff, 1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b0, "=",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b0, "=",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b0, "Q",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b0, "U",   1'b0, 3'd0, NO_WANT,                     1'b0},
    '{MODE_DECODE, 1'b0, "J",   1'b0, 3'd0, NO_WANT,                     1'b0},
    // mode switch with three characters held: encode takes the two newest and this byte
    '{MODE_ENCODE, 1'b1, 8'h00, 1'b1, 3'd0, NO_WANT,                     1'b0}
  };

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       cfg_we   = 1'b0;
  logic       cfg_idx  = CFG_MODE;
  logic       cfg_data = 1'b0;
  logic       s_valid  = 1'b0;
  logic [7:0] s_data   = 8'h00;
  logic       s_last   = 1'b0;
  logic       m_ready  = 1'b0;
  logic       s_ready;
  logic       m_valid;
  logic [7:0] m_data;
  logic       m_last;
  logic       m_user;

  // predictor copy of the codec state and its settings
  logic        pred_mode = MODE_ENCODE;
  logic        pred_nul  = 1'b1;
  logic [23:0] pred_bits = '0;
  logic [1:0]  pred_cnt  = '0;
  logic        pred_pad  = 1'b0;

  codec_out_t  step_out[$];   // results of the request just predicted
  codec_out_t  pending_q[$];  // results still to come, oldest first
  logic [7:0]  msg_q[$];      // message being built for the random part

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes   = 0;
  int unsigned errors       = 0;
  int unsigned stall_cycles = 0;
  bit          calm         = 1'b0;   // no idling on either side
  bit          long_hold    = 1'b0;   // asks the receiver for one long hold-off

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  base64_codec dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // data_byte
    .s_axis_tlast_i  (s_last),   // msg_end
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // out_byte
    .m_axis_tlast_o  (m_last),   // out_last
    .m_axis_tuser_o  (m_user)    // error
  );

  // alphabet character to its 6-bit value, anything else counts as zero
  function automatic logic [5:0] alpha_value(input logic [7:0] c);
    alpha_value = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (B64_ALPHA[i] == c) begin
        alpha_value = i[5:0];
      end
    end
  endfunction

  function automatic void emit_byte(input logic [7:0] d);
    step_out.push_back('{d, 1'b0, 1'b0});
  endfunction

  // works out the results of one accepted request and moves the predicted state on
  function automatic void predict_step(input logic [7:0] b, input logic fin);
    logic [2:0]  total;
    logic [23:0] bits;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [5:0]  v0;
    logic [5:0]  v1;
    logic [5:0]  v2;
    logic [5:0]  v3;
    logic        bad_len;
    codec_out_t  tail;
    total   = {1'b0, pred_cnt} + 3'd1;
    bits    = {pred_bits[15:0], b};
    c1      = pred_bits[15:8];
    c2      = pred_bits[7:0];
    v0      = alpha_value(pred_bits[23:16]);
    v1      = alpha_value(c1);
    v2      = alpha_value(c2);
    v3      = alpha_value(b);
    bad_len = 1'b0;
    step_out.delete();
    if (pred_mode == MODE_ENCODE) begin
      // three bytes gathered, or a held decode group left over from a mode switch
      if (total >= 3'd3) begin
        emit_byte(B64_ALPHA[bits[23:18]]);
        emit_byte(B64_ALPHA[bits[17:12]]);
        emit_byte(B64_ALPHA[bits[11:6]]);
        emit_byte(B64_ALPHA[bits[5:0]]);
        total = 3'd0;
        bits  = '0;
      end
      if (fin && total == 3'd1) begin
        emit_byte(B64_ALPHA[bits[7:2]]);
        emit_byte(B64_ALPHA[{bits[1:0], 4'b0000}]);
        emit_byte(PAD_CHAR);
        emit_byte(PAD_CHAR);
      end else if (fin && total == 3'd2) begin
        emit_byte(B64_ALPHA[bits[15:10]]);
        emit_byte(B64_ALPHA[bits[9:4]]);
        emit_byte(B64_ALPHA[{bits[3:0], 2'b00}]);
        emit_byte(PAD_CHAR);
      end
    end else begin
      if (total == 3'd4) begin
        // once a pad has stopped the message, whole groups only count towards the length
        if (!pred_pad) begin
          emit_byte({v0, v1[5:4]});
          if (c1 == PAD_CHAR || c2 == PAD_CHAR) begin
            pred_pad = 1'b1;
          end else begin
            emit_byte({v1[3:0], v2[5:2]});
            if (c2 == PAD_CHAR || b == PAD_CHAR) begin
              pred_pad = 1'b1;
            end else begin
              emit_byte({v2[1:0], v3});
            end
          end
        end
        total = 3'd0;
        bits  = '0;
      end
      bad_len = fin && total != 3'd0;
    end
    if (fin) begin
      // a message end always shows up, as a bare zero byte if nothing else
      if (pred_nul || step_out.size() == 0) begin
        emit_byte(8'h00);
      end
      tail      = step_out.pop_back();
      tail.last = 1'b1;
      tail.err  = bad_len;
      step_out.push_back(tail);
      pred_cnt  = '0;
      pred_bits = '0;
      pred_pad  = 1'b0;
    end else begin
      pred_cnt  = total[1:0];
      pred_bits = bits;
    end
  endfunction

  // offers one request, waits for the handshake and books its expected results;
  // valid stays high after the handshake, so back-to-back requests follow without a gap
  task automatic send_req(input logic [7:0] d, input logic fin, input logic [2:0] pin_n,
                          input logic [0:4][7:0] pin_bytes, input logic pin_err);
    s_valid <= 1'b1;
    s_data  <= d;
    s_last  <= fin;
    do @(posedge clk_i); while (!s_ready);
    predict_step(d, fin);
    // directed rows with typed-in results replace the predicted ones
    if (pin_n != 3'd0) begin
      step_out.delete();
      for (int i = 0; i < pin_n; i++) begin
        step_out.push_back('{pin_bytes[i], i == pin_n - 1, (i == pin_n - 1) && pin_err});
      end
    end
    foreach (step_out[i]) begin
      pending_q.push_back(step_out[i]);
    end
    items_sent++;
    // the last stretch of the run goes without idling
    calm = (items_sent >= CALM_FROM);
  endtask

  // random sender gap between requests
  task automatic idle_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // sender pauses until every booked result is out and the front end has gone quiet
  task automatic settle();
    s_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes the mode register, then the append_nul register
  task automatic write_config(input logic mode_sel, input logic nul_sel);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MODE;
    cfg_data <= mode_sel;
    @(posedge clk_i);
    cfg_idx  <= CFG_APPEND_NUL;
    cfg_data <= nul_sel;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    pred_mode = mode_sel;
    pred_nul  = nul_sel;
    cfg_writes++;
  endtask

  // one random message for the current mode
  task automatic build_msg();
    int unsigned idx;
    msg_q.delete();
    if (pred_mode == MODE_ENCODE) begin
      repeat ($urandom_range(1, 10)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      // mostly well-formed text: whole groups, maybe padded at the end
      repeat ($urandom_range(1, 3)) begin
        repeat (4) msg_q.push_back(B64_ALPHA[$urandom_range(0, 63)]);
      end
      case ($urandom_range(0, 2))
        1: msg_q[msg_q.size() - 1] = PAD_CHAR;
        2: begin
          msg_q[msg_q.size() - 1] = PAD_CHAR;
          msg_q[msg_q.size() - 2] = PAD_CHAR;
        end
        default: ;
      endcase
      // about a third gets broken: stray bytes, early pads, wrong lengths
      if ($urandom_range(0, 2) == 0) begin
        idx = $urandom_range(0, msg_q.size() - 1);
        case ($urandom_range(0, 3))
          0: msg_q[idx] = 8'($urandom_range(0, 255));
          1: msg_q[idx] = PAD_CHAR;
          2: repeat ($urandom_range(1, 3)) begin
            if (msg_q.size() > 1) void'(msg_q.pop_back());
          end
          default: repeat ($urandom_range(1, 5)) begin
            msg_q.push_back($urandom_range(0, 1) ? B64_ALPHA[$urandom_range(0, 63)]
                                                 : 8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
  endtask

  // receiver: short random stalls, plus one long hold-off when asked for
  initial begin : result_sink
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
        m_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // result checker and stall counter; everything is sampled as it stood before the edge
  always @(posedge clk_i) begin : result_check
    codec_out_t want;
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (rst_ni && m_valid && m_ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result %02h last %b error %b arrived with nothing expected",
                 $time, m_data, m_last, m_user);
      end else begin
        want = pending_q.pop_front();
        if (m_data !== want.data) begin
          errors++;
          $display("%0t: out_byte expected %02h got %02h", $time, want.data, m_data);
        end
        if (m_last !== want.last) begin
          errors++;
          $display("%0t: out_last expected %b got %b", $time, want.last, m_last);
        end
        if (m_user !== want.err) begin
          errors++;
          $display("%0t: error expected %b got %b", $time, want.err, m_user);
        end
      end
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, pending_q.size());
    $display("base64_codec_tb failed");
    $finish;
  end

  initial begin : stimulus
    logic        mode_sel;
    logic        nul_sel;
    int unsigned phase;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, starting from the reset settings
    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].mode != pred_mode || DIR_TABLE[i].nul != pred_nul) begin
        settle();
        write_config(DIR_TABLE[i].mode, DIR_TABLE[i].nul);
      end
      send_req(DIR_TABLE[i].data, DIR_TABLE[i].fin, DIR_TABLE[i].want_n,
               DIR_TABLE[i].want, DIR_TABLE[i].want_err);
      idle_gap();
    end

    // random part: the first four phases walk all corner settings, then random ones;
    // a phase may end inside a message so that the next setting finds a part group
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      settle();
      if (phase < 4) begin
        mode_sel = phase[0];
        nul_sel  = phase[1];
      end else begin
        mode_sel = 1'($urandom_range(0, 1));
        nul_sel  = 1'($urandom_range(0, 1));
      end
      write_config(mode_sel, nul_sel);
      // receiver holds off while the sender keeps pushing, backing the codec up
      if (phase == 2) begin
        long_hold = 1'b1;
      end
      repeat ($urandom_range(4, 8)) begin
        build_msg();
        foreach (msg_q[i]) begin
          send_req(msg_q[i], i == msg_q.size() - 1, 3'd0, NO_WANT, 1'b0);
          idle_gap();
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 3)) begin
          send_req(8'($urandom_range(0, 255)), 1'b0, 3'd0, NO_WANT, 1'b0);
          idle_gap();
        end
      end
      phase++;
    end

    // drain, then a short quiet stretch to catch stray results
    s_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d requests and %0d results over %0d register settings", items_sent,
             results_seen, cfg_writes);
    $display("both modes, terminator on and off, pads, bad lengths, mode switch mid-message");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("base64_codec_tb passed");
    end else begin
      $display("base64_codec_tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/b64_pkg.sv
sv/b64_front.sv
sv/b64_fifo.sv
sv/b64_back.sv
sv/base64_codec.sv
dv/base64_codec_tb.sv
